[hw/rtl/rlars_pkg.sv]
`default_nettype none
package rlars_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int IDX_W      = 10;
    localparam int SUM_W      = 64;
    localparam int SLOPE_W    = 32;
    localparam int OFFSET_W   = 48;

    localparam logic [IDX_W-1:0] LAST_LEAF = IDX_W'(LEAF_COUNT - 1);

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

endpackage
`default_nettype wire

[hw/rtl/range_linear_add_range_sum_tree.sv]
// flow: an accepted item walks lo..hi in S_RUN, then S_DRAIN; a query then goes to S_OUT,
// which loads the output register; throughput: one item at a time, one leaf per cycle
// while walking; a query result sits in an output register, and a held result stalls the
// next query in S_OUT until it is taken
// an empty range skips the walk: a query goes straight to S_OUT, an update stays in S_IDLE
// reset: synchronous active low; then a clearing pass zeroes the whole leaf memory,
// during which no item is accepted
`default_nettype none
module range_linear_add_range_sum_tree
    import rlars_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_op,
    input  wire logic [IDX_W-1:0]           i_lo_index,
    input  wire logic [IDX_W-1:0]           i_hi_index,
    input  wire logic signed [SLOPE_W-1:0]  i_slope,
    input  wire logic signed [OFFSET_W-1:0] i_offset,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [SUM_W-1:0]         o_range_sum
);

    t_state r_state, n_state;

    // leaf value memory
    logic [SUM_W-1:0] mem [LEAF_COUNT];
    logic [SUM_W-1:0] r_rd_data;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic [SUM_W-1:0] wr_data;

    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         r_hi;
    logic                     r_op;
    logic signed [SLOPE_W-1:0]  r_slope;
    logic signed [OFFSET_W-1:0] r_offset;
    logic                     r_p_vld;
    logic [IDX_W-1:0]         r_p_idx;
    logic [SUM_W-1:0]         r_term;
    logic [SUM_W-1:0]         r_acc;
    logic                     r_out_vld;
    logic [SUM_W-1:0]         r_out;

    logic [IDX_W:0]   hi_sat;
    logic             empty;
    logic             in_beat;
    logic signed [SLOPE_W+IDX_W:0] prod;

    // saturate hi to the last leaf and detect an empty range
    always_comb begin
        if ({1'b0, i_hi_index} >= (IDX_W+1)'(LEAF_COUNT)) begin
            hi_sat = {1'b0, LAST_LEAF};
        end else begin
            hi_sat = {1'b0, i_hi_index};
        end
        empty = {1'b0, i_lo_index} > hi_sat;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign in_beat     = i_valid && o_ready;
    assign o_valid     = r_out_vld;
    assign o_range_sum = r_out;

    // linear term for the leaf being read
    assign prod = r_slope * $signed({1'b0, r_idx});

    // memory write port: clearing pass or update write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            we      = 1'b1;
            wr_addr = r_idx;
            wr_data = '0;
        end else begin
            we      = r_p_vld && (r_op == OP_ADD);
            wr_addr = r_p_idx;
            wr_data = r_rd_data + r_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_idx];
    end

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_LEAF) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_beat) begin
                    if (empty) begin
                        n_state = (i_op == OP_QUERY) ? S_OUT : S_IDLE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_idx == r_hi) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = (r_op == OP_QUERY) ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!r_out_vld || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= (r_state == S_RUN);
            // index walk
            if (r_state == S_CLEAR) begin
                r_idx <= (r_idx == LAST_LEAF) ? '0 : r_idx + 1'b1;
            end else if (in_beat) begin
                r_idx <= i_lo_index;
            end else if (r_state == S_RUN && r_idx != r_hi) begin
                r_idx <= r_idx + 1'b1;
            end
            // result register
            if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == S_OUT && (!r_out_vld || i_ready)) begin
                r_out_vld <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_hi     <= hi_sat[IDX_W-1:0];
            r_op     <= i_op;
            r_slope  <= i_slope;
            r_offset <= i_offset;
        end
        r_p_idx <= r_idx;
        r_term  <= SUM_W'(prod) + SUM_W'(r_offset);
        // sum accumulation over read beats
        if (in_beat) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + r_rd_data;
        end
        if (r_state == S_OUT && (!r_out_vld || i_ready)) begin
            r_out <= r_acc;
        end
    end

endmodule
`default_nettype wire
